@@ rtl/sliding_window_entropy_top_defines.svh @@
// Assertion macros used by the sliding window entropy top module.
`ifndef SLIDING_WINDOW_ENTROPY_TOP_DEFINES_SVH
`define SLIDING_WINDOW_ENTROPY_TOP_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define SWE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define SWE_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ rtl/swe_pkg.sv @@
// Types, constants and the log2 helper of the sliding window entropy block.
package swe_pkg;

  localparam int unsigned SAMPLE_W   = 8;
  localparam int unsigned ENT_W      = 19;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned TERM_W     = 16;
  localparam int unsigned NUM_VALUES = 256;
  localparam int unsigned VAL_W      = 8;
  localparam int unsigned ODATA_W    = 24;

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic en;
    val_t addr;
  } cnt_rd_t;

  typedef struct packed {
    logic en;
    val_t addr;
    cnt_t data;
  } cnt_wr_t;

  // log2(n) in unsigned Q7.24, truncated; n in 1..255. Elaboration use only.
  function automatic logic [30:0] lg_q24(input logic [7:0] n);
    logic [2:0]  k;
    logic [63:0] m;
    logic [30:0] r;
    k = 3'd0;
    for (int j = 1; j < 8; j++) begin
      if ((n >> j) != 8'd0) k = j[2:0];
    end
    m = {56'd0, n} << (6'd30 - {3'd0, k});
    r = {4'd0, k, 24'd0};
    for (int i = 23; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m    = m >> 1;
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/sliding_window_entropy_top.sv @@
// Sliding window Shannon entropy of a signed 8-bit sample stream.
//
// Input channel s_axis: one transaction carries one sample (tdata[7:0], signed).
// Output channel m_axis: one transaction per sample; tdata[18:0] holds the window
// entropy in bits as unsigned Q3.16, tuser flags a full window. During warm-up
// (the first WINDOW samples) the entropy field reads 0 and tuser is low.
// Path: an accepted sample passes the count-up step, the count-down step and the
// output buffer before it shows on m_axis.
// Pacing: each sample needs two read-modify-write passes (count up for the new value, count
// down for the leaving value) on the single read port of the count memory, so the input is
// closed while the leaving count is read; the next sample may enter in the count-down step.
// Reset: counts read as zero at once through per-entry valid bits; no sweep is
// run, so the block takes samples from the first cycle after reset.
// Stall: results wait in a two-entry output buffer. At most two samples are
// outstanding (in the count steps or waiting in the buffer), so the input stalls
// while two are held, also in a cycle in which the receiver takes one.
`include "sliding_window_entropy_top_defines.svh"

module sliding_window_entropy_top #(
  parameter int unsigned WINDOW = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [swe_pkg::SAMPLE_W-1:0]  s_axis_tdata,   // [7:0] sample
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [swe_pkg::ODATA_W-1:0]   m_axis_tdata,   // [18:0] entropy, [23:19] zero
  output logic                          m_axis_tuser    // [0] window_full
);
  import swe_pkg::*;

  localparam int unsigned IdxW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned WarmW    = $clog2(WINDOW + 1);
  localparam int unsigned TermDen  = WINDOW * 256;
  localparam int unsigned TermHalf = TermDen / 2;

  // Term for count c: round(c * (lg(WINDOW) - lg(c)) / (WINDOW * 256)).
  function automatic logic [TERM_W-1:0] term_calc(input int unsigned c);
    logic [63:0] l;
    logic [63:0] p;
    if (c == 0) begin
      return '0;
    end
    l = 64'(lg_q24(8'(WINDOW))) - 64'(lg_q24(8'(c)));
    p = (64'(c) * l + 64'(TermHalf)) / TermDen;
    return TERM_W'(p);
  endfunction

  // Term ROM, constant at elaboration.
  logic [TERM_W-1:0] term_rom [WINDOW];
  for (genvar g = 0; g < WINDOW; g++) begin : g_rom
    assign term_rom[g] = term_calc(g);
  end

  // Input side and sequencing.
  logic             in_acc;
  val_t             in_val;
  logic [IdxW-1:0]  ptr_q;
  logic [WarmW-1:0] warm_q;
  logic             in_full;
  logic [1:0]       outst_q;
  logic             ph1_q, ph2_q;
  logic             full1_q, full2_q;
  val_t             v1_q, old2_q;

  // Delay line memory (value indices).
  val_t dl_mem [WINDOW];
  val_t dl_rd_q;

  // Count memory ports.
  cnt_rd_t cnt_rd;
  cnt_wr_t cnt_wr;
  cnt_t    cnt_cur;
  cnt_t    cnt_new;

  // Entropy.
  logic [ENT_W-1:0]  ent_q, ent_d;
  logic [TERM_W-1:0] term_old, term_new;
  logic              ent_upd;

  // Output buffer.
  logic             push, pop;
  logic [ENT_W-1:0] push_ent;
  logic             out_vld_q, skid_vld_q;
  logic [ENT_W-1:0] out_ent_q, skid_ent_q;
  logic             out_full_q, skid_full_q;
  logic             out_load, out_from_skid, skid_load;

  // Take a sample unless one entered last cycle or two are outstanding.
  assign s_axis_tready = !ph1_q && (outst_q != 2'd2);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_val        = {~s_axis_tdata[SAMPLE_W-1], s_axis_tdata[SAMPLE_W-2:0]};
  assign in_full       = (32'(warm_q) == WINDOW);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dl_rd_q        <= dl_mem[ptr_q];
      dl_mem[ptr_q]  <= in_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= '0;
      warm_q  <= '0;
      ph1_q   <= 1'b0;
      ph2_q   <= 1'b0;
      full1_q <= 1'b0;
      full2_q <= 1'b0;
      outst_q <= '0;
      ent_q   <= '0;
    end else begin
      ph1_q   <= in_acc;
      ph2_q   <= ph1_q;
      full2_q <= full1_q;
      outst_q <= outst_q + {1'b0, in_acc} - {1'b0, pop};
      if (in_acc) begin
        full1_q <= in_full;
        ptr_q   <= (32'(ptr_q) == WINDOW - 1) ? '0 : ptr_q + 1'b1;
        if (!in_full) begin
          warm_q <= warm_q + 1'b1;
        end
      end
      if (ent_upd) begin
        ent_q <= ent_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      v1_q <= in_val;
    end
    if (ph1_q) begin
      old2_q <= dl_rd_q;
    end
  end

  // Read the new value's count at accept, the leaving value's count in the next cycle once the window is full.
  always_comb begin
    cnt_rd.en   = in_acc || (ph1_q && full1_q);
    cnt_rd.addr = in_acc ? in_val : dl_rd_q;
  end

  // Count up in the first step, count down in the second.
  assign cnt_new = ph1_q ? cnt_cur + 1'b1 : cnt_cur - 1'b1;

  always_comb begin
    cnt_wr.en   = ph1_q || (ph2_q && full2_q);
    cnt_wr.addr = ph1_q ? v1_q : old2_q;
    cnt_wr.data = cnt_new;
  end

  swe_cnt_ram u_cnt_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_i      (cnt_rd),
    .wr_i      (cnt_wr),
    .rd_data_o (cnt_cur)
  );

  // Swap the old term for the new; counts of WINDOW and above contribute 0.
  always_comb begin
    term_old = (32'(cnt_cur) < WINDOW) ? term_rom[cnt_cur[IdxW-1:0]] : '0;
    term_new = (32'(cnt_new) < WINDOW) ? term_rom[cnt_new[IdxW-1:0]] : '0;
    ent_upd  = cnt_wr.en;
    ent_d    = ent_q - {{(ENT_W-TERM_W){1'b0}}, term_old}
                     + {{(ENT_W-TERM_W){1'b0}}, term_new};
  end

  // Result leaves the second step.
  assign push     = ph2_q;
  assign push_ent = full2_q ? ent_d : '0;
  assign pop      = out_vld_q && m_axis_tready;

  assign out_from_skid = pop && skid_vld_q;
  assign out_load      = push && (!out_vld_q || (pop && !skid_vld_q));
  assign skid_load     = push && !out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_load || out_from_skid || (out_vld_q && !pop);
      skid_vld_q <= skid_load || (skid_vld_q && !pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_from_skid) begin
      out_ent_q  <= skid_ent_q;
      out_full_q <= skid_full_q;
    end else if (out_load) begin
      out_ent_q  <= push_ent;
      out_full_q <= full2_q;
    end
    if (skid_load) begin
      skid_ent_q  <= push_ent;
      skid_full_q <= full2_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(ODATA_W-ENT_W){1'b0}}, out_ent_q};
  assign m_axis_tuser  = out_full_q;

  // The count-up step and the count-down step are never active together.
  `SWE_ASSERT_NEVER(a_steps_excl, ph1_q && ph2_q, "count steps overlap")
  // A result never arrives at a full output buffer that is not draining.
  `SWE_ASSERT_NEVER(a_no_overflow, push && skid_vld_q && !pop, "output buffer overflow")
  // Buffered results are always counted as outstanding.
  `SWE_ASSERT(a_outst_cover, 2'(out_vld_q) + 2'(skid_vld_q) <= outst_q, "outstanding count too low")
  // A full-window result implies the warm-up has ended.
  `SWE_ASSERT(a_full_warm, (m_axis_tvalid && m_axis_tuser) |-> in_full, "full window during warm-up")

endmodule

@@ rtl/swe_cnt_ram.sv @@
// Value count memory: 256 counts, read-first, cleared by valid bits, with write bypass.
module swe_cnt_ram (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  swe_pkg::cnt_rd_t rd_i,
  input  swe_pkg::cnt_wr_t wr_i,
  output swe_pkg::cnt_t    rd_data_o
);
  import swe_pkg::*;

  cnt_t                  mem [NUM_VALUES];
  cnt_t                  mem_rd_q;
  logic [NUM_VALUES-1:0] vld_q;
  logic                  rd_vld_q;
  logic                  byp_q;
  cnt_t                  byp_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      mem_rd_q <= mem[rd_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      byp_q    <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_i.en) begin
        rd_vld_q <= vld_q[rd_i.addr];
        // forward a write to the same entry issued in the read cycle
        byp_q    <= wr_i.en && (wr_i.addr == rd_i.addr);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      byp_data_q <= wr_i.data;
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : (rd_vld_q ? mem_rd_q : '0);

endmodule
